[rtl/core/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// shared types, sizes and codes of the stable priority packet queue
// ----------------------------------------------------------------------------
package spq_pkg;

  // number of cells in the chain
  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  localparam int PRIO_W  = 3;
  localparam int TIME_W  = 16;
  localparam int STAT_W  = 2;
  localparam int OCC_W   = 5;

  // request kinds
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_POP    = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] duration;
  } entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t entry;
  } cmd_t;

  // where a cell sits relative to the fill count
  typedef struct packed {
    logic occ;
    logic tail;
  } pos_t;

endpackage

[rtl/core/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: compares the new key and shifts with neighbors
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic           clk,
  input  spq_pkg::cmd_t  cmd,
  input  spq_pkg::pos_t  pos,
  input  spq_pkg::entry_t left_entry,
  input  logic           left_ins,
  input  spq_pkg::entry_t right_entry,
  output spq_pkg::entry_t entry,
  output logic           ins_here
);

  logic goes_before;

  // new key is strictly ahead of the stored one; ties stay behind
  assign goes_before = (cmd.entry.prio > entry.prio) ||
                       ((cmd.entry.prio == entry.prio) &&
                        (cmd.entry.arrival < entry.arrival));

  assign ins_here = pos.tail || (pos.occ && goes_before);

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      if (left_ins) begin
        entry <= left_entry;
      end else if (ins_here) begin
        entry <= cmd.entry;
      end
    end else if (cmd.pop) begin
      entry <= right_entry;
    end
  end

endmodule

[rtl/core/stable_priority_packet_queue.sv]
// ----------------------------------------------------------------------------
// stable_priority_packet_queue
// sorted descriptor queue built as a chain of compare-and-shift cells
// ----------------------------------------------------------------------------
// Each request either inserts a descriptor (priority, arrival, transmission
// time) at its sorted place or pops the front one. Order is higher priority
// first, then earlier arrival; exact ties leave in first-in order. On each
// request all cells compare the new key against their own entry in
// parallel and each loads from its left neighbor, the new key, its right
// neighbor or itself, so the whole cell chain updates together. One
// result register sits on the output; a new request is taken in the same
// cycle the pending result is taken, so the sustained rate is one request per
// cycle while the consumer keeps out_ready high. A pop on an empty queue
// returns status 1 and an insert into a full queue is dropped with status 2;
// both leave the queue unchanged. occupancy is the entry count after the
// request. There is no clearing pass: only the count and out_valid are reset.
// ----------------------------------------------------------------------------
module stable_priority_packet_queue (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             action,
  input  logic [spq_pkg::PRIO_W-1:0]       prio,
  input  logic [spq_pkg::TIME_W-1:0]       arrival_time,
  input  logic [spq_pkg::TIME_W-1:0]       transmission_time,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [spq_pkg::STAT_W-1:0]       status,
  output logic [spq_pkg::PRIO_W-1:0]       out_prio,
  output logic [spq_pkg::TIME_W-1:0]       out_arrival,
  output logic [spq_pkg::TIME_W-1:0]       out_transmission,
  output logic [spq_pkg::OCC_W-1:0]        occupancy
);

  logic [spq_pkg::CNT_W-1:0] count;
  logic [spq_pkg::CNT_W-1:0] count_next;
  logic                      accept;
  logic                      empty;
  logic                      full;
  spq_pkg::cmd_t             cmd;

  spq_pkg::entry_t           cell_entry [spq_pkg::DEPTH];
  logic                      cell_ins   [spq_pkg::DEPTH];

  // result register frees up when it is empty or being taken; no requests in reset
  assign in_ready = !rst && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign empty    = (count == '0);
  assign full     = (count == spq_pkg::CNT_W'(spq_pkg::DEPTH));

  always_comb begin
    cmd.push           = accept && (action == spq_pkg::ACT_INSERT) && !full;
    cmd.pop            = accept && (action == spq_pkg::ACT_POP) && !empty;
    cmd.entry.prio     = prio;
    cmd.entry.arrival  = arrival_time;
    cmd.entry.duration = transmission_time;
  end

  always_comb begin
    count_next = count;
    if (cmd.push) begin
      count_next = count + 1'b1;
    end else if (cmd.pop) begin
      count_next = count - 1'b1;
    end
  end

  // the chain; cell 0 is the front of the queue
  for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
    spq_pkg::pos_t   pos;
    spq_pkg::entry_t left_entry;
    spq_pkg::entry_t right_entry;
    logic            left_ins;

    assign pos.occ  = (spq_pkg::CNT_W'(i) < count);
    assign pos.tail = (spq_pkg::CNT_W'(i) == count);

    if (i == 0) begin : g_first
      // nothing to the left of the front
      assign left_entry = cmd.entry;
      assign left_ins   = 1'b0;
    end else begin : g_mid
      assign left_entry = cell_entry[i-1];
      assign left_ins   = cell_ins[i-1];
    end

    if (i == spq_pkg::DEPTH - 1) begin : g_last
      // last cell holds on a pop, it is no longer counted anyway
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .pos         (pos),
      .left_entry  (left_entry),
      .left_ins    (left_ins),
      .right_entry (right_entry),
      .entry       (cell_entry[i]),
      .ins_here    (cell_ins[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded with each request
  always_ff @(posedge clk) begin
    if (accept) begin
      status           <= spq_pkg::ST_OK;
      out_prio         <= '0;
      out_arrival      <= '0;
      out_transmission <= '0;
      occupancy        <= spq_pkg::OCC_W'(count_next);
      if (action == spq_pkg::ACT_POP) begin
        if (empty) begin
          status <= spq_pkg::ST_EMPTY;
        end else begin
          out_prio         <= cell_entry[0].prio;
          out_arrival      <= cell_entry[0].arrival;
          out_transmission <= cell_entry[0].duration;
        end
      end else if (full) begin
        status <= spq_pkg::ST_FULL;
      end
    end
  end

  // count never passes the number of cells
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= spq_pkg::CNT_W'(spq_pkg::DEPTH))
    else $error("entry count above depth");

  // a pending result always reports the current count
  a_occ_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (occupancy == spq_pkg::OCC_W'(count)))
    else $error("occupancy out of step with count");

  // the two front entries stay in sorted order
  a_front_sorted: assert property (@(posedge clk) disable iff (rst)
    (count >= spq_pkg::CNT_W'(2)) |->
      ((cell_entry[0].prio > cell_entry[1].prio) ||
       ((cell_entry[0].prio == cell_entry[1].prio) &&
        (cell_entry[0].arrival <= cell_entry[1].arrival))))
    else $error("front entries out of order");

  // a pop on an empty queue reports the error and leaves the count alone
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (accept && (action == spq_pkg::ACT_POP) && empty) |=>
      ((status == spq_pkg::ST_EMPTY) && (count == '0)))
    else $error("pop on empty mishandled");

  // a dropped insert keeps the queue full
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (accept && (action == spq_pkg::ACT_INSERT) && full) |=>
      ((status == spq_pkg::ST_FULL) && $stable(count)))
    else $error("insert on full mishandled");

endmodule
